### rtl/core/credential_hash_table_defines.svh
// Assertion macros used by the credential hash table RTL.
`ifndef CREDENTIAL_HASH_TABLE_DEFINES_SVH
`define CREDENTIAL_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet during reset.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cht_pkg.sv
// Types, constants and codes of the credential hash table.
package cht_pkg;

    localparam int DEPTH     = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int HASH_W    = 32;
    localparam int IDX_W     = 5;
    localparam int CNT_OUT_W = 6;

    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_READ       = 3'd1;
    localparam logic [2:0] OP_WRITE      = 3'd2;
    localparam logic [2:0] OP_FIND       = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_SET_CURSOR = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        op;
        logic              pick_pin;
        logic              use_cursor;
        logic [IDX_W-1:0]  index;
        logic [HASH_W-1:0] first_value;
        logic [HASH_W-1:0] second_value;
    } t_in_item;

    typedef struct packed {
        logic                 ok;
        logic [HASH_W-1:0]    hash_out;
        logic [IDX_W-1:0]     found_index;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 cursor_valid;
        logic [IDX_W-1:0]     cursor_index;
    } t_out_item;

    typedef struct packed {
        logic              wr_id;
        logic              wr_pin;
        logic [ADDR_W-1:0] wr_addr;
        logic [HASH_W-1:0] wr_id_data;
        logic [HASH_W-1:0] wr_pin_data;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_pin;
    } t_store_ctl;

endpackage

### rtl/core/cht_store.sv
// Hash storage: ID and PIN columns with one write port and a registered read.
module cht_store
    import cht_pkg::*;
(
    input  logic              i_clk,
    input  t_store_ctl        i_ctl,
    output logic [HASH_W-1:0] o_rd_data
);

    logic [HASH_W-1:0] r_id_mem  [DEPTH];
    logic [HASH_W-1:0] r_pin_mem [DEPTH];
    logic [HASH_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_id) begin
            r_id_mem[i_ctl.wr_addr] <= i_ctl.wr_id_data;
        end
        if (i_ctl.wr_pin) begin
            r_pin_mem[i_ctl.wr_addr] <= i_ctl.wr_pin_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_pin) begin
            r_rd_data <= r_pin_mem[i_ctl.rd_addr];
        end else begin
            r_rd_data <= r_id_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/credential_hash_table.sv
// Sequence: a word is accepted in ST_IDLE and executed in ST_EXEC; a read that succeeds
// then passes ST_RDWAIT, and a find on a non-empty table compares entries in ST_SCAN
// until a hit or the last entry. Every word then reaches ST_DONE. Words are taken one at
// a time; the single store read port and one shared comparator set the find's worst case.
// A finished result waits in the output register while the next word is accepted.
// Reset (synchronous, active low) empties the table and disables the cursor; hashes stay.
`include "credential_hash_table_defines.svh"

module credential_hash_table
    import cht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Sequencer state and the word under work.
    t_state            r_state, n_state;
    t_in_item          r_item, n_item;

    // Table bookkeeping.
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_cursor, n_cursor;
    logic              r_cursor_on, n_cursor_on;

    // Result under construction and the find scan position.
    logic              r_ok, n_ok;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [IDX_W-1:0]  r_found, n_found;
    logic [ADDR_W-1:0] r_scan, n_scan;

    // Output register, parts the result side from the input side.
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;

    // Store access.
    t_store_ctl        store_ctl;
    logic [HASH_W-1:0] rd_data;

    // Shared decode.
    logic [IDX_W-1:0]  pos;
    logic              pos_ok;
    logic              full;
    logic              hit;
    logic              scan_last;
    logic              out_free;

    assign pos       = r_item.use_cursor ? r_cursor : r_item.index;
    assign pos_ok    = (!r_item.use_cursor || r_cursor_on) && (CNT_W'(pos) < r_count);
    assign full      = (r_count == CNT_W'(DEPTH));
    // One comparator serves the whole find scan.
    assign hit       = (rd_data == r_item.first_value);
    assign scan_last = ((CNT_W'(r_scan) + CNT_W'(1)) >= r_count);
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    cht_store u_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .o_rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_item.op == OP_READ && pos_ok) begin
                    n_state = ST_RDWAIT;
                end else if (r_item.op == OP_FIND && r_count != '0) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RDWAIT: begin
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (hit || scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and store control.
    always_comb begin
        n_item      = r_item;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_cursor_on = r_cursor_on;
        n_ok        = r_ok;
        n_hash      = r_hash;
        n_found     = r_found;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        store_ctl.wr_id       = 1'b0;
        store_ctl.wr_pin      = 1'b0;
        store_ctl.wr_addr     = ADDR_W'(pos);
        store_ctl.wr_id_data  = r_item.first_value;
        store_ctl.wr_pin_data = r_item.first_value;
        store_ctl.rd_addr     = ADDR_W'(pos);
        store_ctl.rd_pin      = r_item.pick_pin;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                end
            end
            ST_EXEC: begin
                n_ok    = 1'b0;
                n_hash  = '0;
                n_found = '0;
                case (r_item.op)
                    OP_APPEND: begin
                        if (!full) begin
                            store_ctl.wr_id       = 1'b1;
                            store_ctl.wr_pin      = 1'b1;
                            store_ctl.wr_addr     = ADDR_W'(r_count);
                            store_ctl.wr_pin_data = r_item.second_value;
                            n_count = r_count + CNT_W'(1);
                            if (!r_cursor_on) begin
                                n_cursor_on = 1'b1;
                                n_cursor    = '0;
                            end
                            n_ok = 1'b1;
                        end
                    end
                    OP_READ: begin
                        // Read address is pos by default; data lands next cycle.
                    end
                    OP_WRITE: begin
                        if (pos_ok) begin
                            store_ctl.wr_id  = !r_item.pick_pin;
                            store_ctl.wr_pin = r_item.pick_pin;
                            n_ok = 1'b1;
                        end
                    end
                    OP_FIND: begin
                        // Prime the scan with the first entry.
                        store_ctl.rd_addr = '0;
                        n_scan = '0;
                    end
                    OP_CLEAR: begin
                        n_count     = '0;
                        n_cursor    = '0;
                        n_cursor_on = 1'b0;
                        n_ok        = 1'b1;
                    end
                    OP_SET_CURSOR: begin
                        if (CNT_W'(r_item.index) < r_count) begin
                            n_cursor = r_item.index;
                            n_ok     = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_RDWAIT: begin
                n_hash = rd_data;
                n_ok   = 1'b1;
            end
            ST_SCAN: begin
                // Fetch the next entry while comparing the current one.
                store_ctl.rd_addr = r_scan + ADDR_W'(1);
                if (hit) begin
                    n_ok    = 1'b1;
                    n_found = IDX_W'(r_scan);
                end else begin
                    n_scan = r_scan + ADDR_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.ok            = r_ok;
                    n_out_data.hash_out      = r_hash;
                    n_out_data.found_index   = r_found;
                    n_out_data.entry_count   = CNT_OUT_W'(r_count);
                    n_out_data.cursor_valid  = r_cursor_on;
                    n_out_data.cursor_index  = r_cursor_on ? r_cursor : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_cursor_on <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_cursor_on <= n_cursor_on;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_ok       <= n_ok;
        r_hash     <= n_hash;
        r_found    <= n_found;
        r_scan     <= n_scan;
        r_out_data <= n_out_data;
    end

    // Hold the entry count within the table.
    `CHT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "entry count beyond depth")
    // Keep the cursor enabled exactly while the table holds entries.
    `CHT_ASSERT_NOW(a_cursor_tracks_count, 1'b1, (r_count != '0) == r_cursor_on,
                    "cursor enable out of step with entry count")
    // Advance an accepted word straight into execution.
    `CHT_ASSERT_NEXT(a_accept_exec, i_in_valid && o_in_ready, r_state == ST_EXEC,
                     "accepted word did not enter execution")
    // Keep the find scan inside the filled part of the table.
    `CHT_ASSERT_NOW(a_scan_in_range, r_state == ST_SCAN, CNT_W'(r_scan) < r_count,
                    "find scan beyond entry count")

endmodule
